>>> hdl/binary_max_heap_priority_queue_top_assert.svh
// Assertion macros for the priority queue RTL.
`ifndef BINARY_MAX_HEAP_PRIORITY_QUEUE_TOP_ASSERT_SVH
`define BINARY_MAX_HEAP_PRIORITY_QUEUE_TOP_ASSERT_SVH

// Check a property on every rising clock edge, held off while reset is low.
`define BHPQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that an antecedent is followed in the next cycle by a consequent.
`define BHPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/bhpq_pkg.sv
`default_nettype none

package bhpq_pkg;

  localparam int CAPACITY       = 64;
  localparam int VALUE_WIDTH    = 32;
  localparam int COUNT_WIDTH    = $clog2(CAPACITY + 1);
  localparam int IN_DATA_WIDTH  = ((VALUE_WIDTH + 7) / 8) * 8;
  localparam int OUT_DATA_WIDTH = ((VALUE_WIDTH + COUNT_WIDTH + 1 + 7) / 8) * 8;

  typedef enum logic {
    OP_ENQUEUE = 1'b0,
    OP_DEQUEUE = 1'b1
  } bhpq_op_e;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } bhpq_status_e;

  // Command broadcast to every cell of the chain.
  typedef struct packed {
    logic                   insert;
    logic                   remove;
    logic [VALUE_WIDTH-1:0] value;
  } bhpq_cmd_t;

  typedef struct packed {
    logic                   queue_empty;
    logic [COUNT_WIDTH-1:0] entries_held;
    bhpq_status_e           status;
    logic [VALUE_WIDTH-1:0] max_value;
  } bhpq_result_t;

endpackage

`default_nettype wire

>>> hdl/bhpq_cell.sv
`default_nettype none

// One slot of the ordered chain. Slots stay sorted largest first.
module bhpq_cell (
  input  wire logic                            clk_i,
  input  wire bhpq_pkg::bhpq_cmd_t             cmd_i,
  input  wire logic                            occupied_i,
  input  wire logic                            prev_gt_i,
  input  wire logic [bhpq_pkg::VALUE_WIDTH-1:0] prev_val_i,
  input  wire logic [bhpq_pkg::VALUE_WIDTH-1:0] next_val_i,
  output logic [bhpq_pkg::VALUE_WIDTH-1:0]      val_o,
  output logic                                  gt_o
);

  logic [bhpq_pkg::VALUE_WIDTH-1:0] val_q, val_d;

  // An empty slot ranks below any new value.
  assign gt_o = !occupied_i || (cmd_i.value > val_q);

  always_comb begin
    val_d = val_q;
    if (cmd_i.insert) begin
      if (gt_o) begin
        // Take the new value at the boundary, otherwise shift down from above.
        val_d = prev_gt_i ? prev_val_i : cmd_i.value;
      end
    end else if (cmd_i.remove) begin
      val_d = next_val_i;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_o = val_q;

endmodule

`default_nettype wire

>>> hdl/binary_max_heap_priority_queue_top.sv
// The result beat of an item is registered in the output buffer before the master side sees it.
// Throughput: one item per cycle while the output buffer has room; every slot compares against
//   the new value at once, so no comparator chain sets the cycle, independent of the fill level.
// A two-beat output buffer lets a new item enter while an earlier result still waits.
// Reset (rst_ni low, asynchronous) empties the queue and the output buffer;
//   slot contents are not cleared and are only read below the entry count.
`default_nettype none

module binary_max_heap_priority_queue_top (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                s_axis_tvalid_i,
  output logic                                     s_axis_tready_o,
  // tdata: [31:0] item_value
  input  wire logic [bhpq_pkg::IN_DATA_WIDTH-1:0]  s_axis_tdata_i,
  // tuser: [0] opcode
  input  wire logic                                s_axis_tuser_i,
  output logic                                     m_axis_tvalid_o,
  input  wire logic                                m_axis_tready_i,
  // tdata: [31:0] max_value, [38:32] entries_held, [39] queue_empty
  output logic [bhpq_pkg::OUT_DATA_WIDTH-1:0]      m_axis_tdata_o,
  // tuser: [1:0] status
  output logic [1:0]                               m_axis_tuser_o
);

  localparam int W  = bhpq_pkg::VALUE_WIDTH;
  localparam int CW = bhpq_pkg::COUNT_WIDTH;
  localparam int N  = bhpq_pkg::CAPACITY;
  localparam int OUT_DATA_WIDTH = bhpq_pkg::OUT_DATA_WIDTH;

  logic                  in_beat, out_beat;
  logic [CW-1:0]         count_q, count_d;
  logic                  is_full, is_empty;
  bhpq_pkg::bhpq_cmd_t   cmd;
  bhpq_pkg::bhpq_result_t result;

  logic [W-1:0]          cell_val [N];
  logic [N-1:0]          cell_gt;

  // Two-beat result buffer.
  bhpq_pkg::bhpq_result_t fifo_q [2];
  logic                   wr_ptr_q, rd_ptr_q;
  logic [1:0]             level_q;

  assign in_beat  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_beat = m_axis_tvalid_o && m_axis_tready_i;

  assign is_full  = (count_q == CW'(N));
  assign is_empty = (count_q == '0);

  // Decode the accepted beat into a chain command; drop full enqueues and empty dequeues.
  always_comb begin
    cmd.value  = s_axis_tdata_i[W-1:0];
    cmd.insert = in_beat && (s_axis_tuser_i == bhpq_pkg::OP_ENQUEUE) && !is_full;
    cmd.remove = in_beat && (s_axis_tuser_i == bhpq_pkg::OP_DEQUEUE) && !is_empty;
  end

  // Build the result beat: status and max value from the state before the update, count after it.
  always_comb begin
    count_d          = count_q;
    result.max_value = '0;
    result.status    = bhpq_pkg::STATUS_OK;
    if (s_axis_tuser_i == bhpq_pkg::OP_ENQUEUE) begin
      if (is_full) begin
        result.status = bhpq_pkg::STATUS_FULL;
      end else begin
        count_d = count_q + CW'(1);
      end
    end else begin
      if (is_empty) begin
        result.status = bhpq_pkg::STATUS_EMPTY;
      end else begin
        result.max_value = cell_val[0];
        count_d          = count_q - CW'(1);
      end
    end
    result.entries_held = count_d;
    result.queue_empty  = (count_d == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (in_beat) begin
      count_q <= count_d;
    end
  end

  // Chain of slots: each one looks at its upper and lower neighbor only.
  for (genvar i = 0; i < N; i++) begin : g_cell
    logic         occupied;
    logic         prev_gt;
    logic [W-1:0] prev_val, next_val;

    assign occupied = (CW'(i) < count_q);

    if (i == 0) begin : g_head
      assign prev_gt  = 1'b0;
      assign prev_val = '0;
    end else begin : g_body
      assign prev_gt  = cell_gt[i-1];
      assign prev_val = cell_val[i-1];
    end

    if (i == N - 1) begin : g_tail
      assign next_val = cell_val[i];
    end else begin : g_inner
      assign next_val = cell_val[i+1];
    end

    bhpq_cell u_cell (
      .clk_i      (clk_i),
      .cmd_i      (cmd),
      .occupied_i (occupied),
      .prev_gt_i  (prev_gt),
      .prev_val_i (prev_val),
      .next_val_i (next_val),
      .val_o      (cell_val[i]),
      .gt_o       (cell_gt[i])
    );
  end

  // Push the result beat, advance the read side when the master takes one.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      level_q  <= 2'd0;
    end else begin
      if (in_beat) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (out_beat) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      case ({in_beat, out_beat})
        2'b10:   level_q <= level_q + 2'd1;
        2'b01:   level_q <= level_q - 2'd1;
        default: level_q <= level_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      fifo_q[wr_ptr_q] <= result;
    end
  end

  // Hold off the slave side only when both buffer beats are taken.
  assign s_axis_tready_o = (level_q != 2'd2);
  assign m_axis_tvalid_o = (level_q != 2'd0);
  assign m_axis_tdata_o  = OUT_DATA_WIDTH'({fifo_q[rd_ptr_q].queue_empty,
                                            fifo_q[rd_ptr_q].entries_held,
                                            fifo_q[rd_ptr_q].max_value});
  assign m_axis_tuser_o  = fifo_q[rd_ptr_q].status;

`include "binary_max_heap_priority_queue_top_assert.svh"

  `BHPQ_ASSERT(a_count_bound, count_q <= CW'(N), "entry count above capacity")
  `BHPQ_ASSERT(a_head_sorted, (count_q < CW'(2)) || (cell_val[0] >= cell_val[1]), "head slot not the maximum")
  `BHPQ_ASSERT(a_buffer_level, level_q != 2'd3, "result buffer overrun")
  `BHPQ_ASSERT_NEXT(a_enq_grows, cmd.insert, count_q == $past(count_q) + CW'(1), "enqueue lost")
  `BHPQ_ASSERT_NEXT(a_deq_shrinks, cmd.remove, count_q == $past(count_q) - CW'(1), "dequeue lost")

endmodule

`default_nettype wire

>>> sim/binary_max_heap_priority_queue_top_test.sv
`timescale 1ns / 100ps

module binary_max_heap_priority_queue_top_test;

  localparam int VALUE_WIDTH    = bhpq_pkg::VALUE_WIDTH;
  localparam int COUNT_WIDTH    = bhpq_pkg::COUNT_WIDTH;
  localparam int CAPACITY       = bhpq_pkg::CAPACITY;
  localparam int IN_DATA_WIDTH  = bhpq_pkg::IN_DATA_WIDTH;
  localparam int OUT_DATA_WIDTH = bhpq_pkg::OUT_DATA_WIDTH;

  // One result beat as the checker sees it.
  typedef struct packed {
    logic [VALUE_WIDTH-1:0] max_value;
    bhpq_pkg::bhpq_status_e status;
    logic [COUNT_WIDTH-1:0] entries_held;
    logic                   queue_empty;
  } queue_outcome_t;

  // One row of the directed table. Rows with has_answer set carry a typed-in answer;
  // the rest are checked against the heap predictor.
  typedef struct packed {
    bhpq_pkg::bhpq_op_e     op;
    logic [VALUE_WIDTH-1:0] value;
    logic                   has_answer;
    queue_outcome_t         answer;
  } directed_row_t;

  localparam int NUM_DIRECTED = 22;
  localparam logic [VALUE_WIDTH-1:0] TOP_VALUE = '1;
  localparam logic [VALUE_WIDTH-1:0] JUNK_VALUE = 32'hdead_beef;

  // Directed table: empty-queue error after reset, the value extremes, a dequeue that
  // leaves only a left child larger than the moved entry, ties, and ignored payloads.
  localparam directed_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
    '{bhpq_pkg::OP_DEQUEUE, JUNK_VALUE, 1'b1, '{'0, bhpq_pkg::STATUS_EMPTY, 7'd0, 1'b1}},
    '{bhpq_pkg::OP_ENQUEUE, 32'h0,      1'b1, '{'0, bhpq_pkg::STATUS_OK, 7'd1, 1'b0}},
    '{bhpq_pkg::OP_ENQUEUE, TOP_VALUE,  1'b1, '{'0, bhpq_pkg::STATUS_OK, 7'd2, 1'b0}},
    '{bhpq_pkg::OP_DEQUEUE, JUNK_VALUE, 1'b1, '{TOP_VALUE, bhpq_pkg::STATUS_OK, 7'd1, 1'b0}},
    '{bhpq_pkg::OP_DEQUEUE, 32'h0,      1'b1, '{'0, bhpq_pkg::STATUS_OK, 7'd0, 1'b1}},
    '{bhpq_pkg::OP_DEQUEUE, TOP_VALUE,  1'b1, '{'0, bhpq_pkg::STATUS_EMPTY, 7'd0, 1'b1}},
    '{bhpq_pkg::OP_ENQUEUE, 32'd10,        1'b0, '0},
    '{bhpq_pkg::OP_ENQUEUE, 32'd9,         1'b0, '0},
    '{bhpq_pkg::OP_ENQUEUE, 32'd1,         1'b0, '0},
    '{bhpq_pkg::OP_DEQUEUE, 32'h0,         1'b0, '0},
    '{bhpq_pkg::OP_DEQUEUE, 32'h0,         1'b0, '0},
    '{bhpq_pkg::OP_DEQUEUE, 32'h0,         1'b0, '0},
    '{bhpq_pkg::OP_ENQUEUE, 32'd5,         1'b0, '0},
    '{bhpq_pkg::OP_ENQUEUE, 32'd5,         1'b0, '0},
    '{bhpq_pkg::OP_ENQUEUE, 32'd3,         1'b0, '0},
    '{bhpq_pkg::OP_ENQUEUE, 32'd8,         1'b0, '0},
    '{bhpq_pkg::OP_ENQUEUE, 32'h8000_0000, 1'b0, '0},
    '{bhpq_pkg::OP_ENQUEUE, 32'h7fff_ffff, 1'b0, '0},
    '{bhpq_pkg::OP_DEQUEUE, TOP_VALUE,     1'b0, '0},
    '{bhpq_pkg::OP_DEQUEUE, 32'h0,         1'b0, '0},
    '{bhpq_pkg::OP_DEQUEUE, JUNK_VALUE,    1'b0, '0},
    '{bhpq_pkg::OP_DEQUEUE, 32'h0,         1'b0, '0}
  };

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  // Slave side, driven by the sender process.
  logic                      s_valid = 1'b0;
  logic                      s_ready;
  logic [IN_DATA_WIDTH-1:0]  s_data = '0;
  logic                      s_user = 1'b0;

  // Master side, ready driven by the receiver process.
  logic                      m_valid;
  logic                      m_ready = 1'b0;
  logic [OUT_DATA_WIDTH-1:0] m_data;
  logic [1:0]                m_user;

  // Idle rates in percent of cycles, set per phase by the sender process.
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  // Long receiver hold-off: the sender counts up requests, the receiver serves them.
  int hold_requests = 0;
  int holds_served = 0;
  int hold_left = 0;

  // Heap predictor state: 1-based positions, slot = position - 1.
  logic [VALUE_WIDTH-1:0] heap_words [CAPACITY];
  int unsigned            heap_len = 0;

  queue_outcome_t pending_outcomes [$];
  int             mismatch_count = 0;

  binary_max_heap_priority_queue_top uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tuser_o  (m_user)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic void swap_heap_slots(input int unsigned a, input int unsigned b);
    logic [VALUE_WIDTH-1:0] held;
    held = heap_words[a];
    heap_words[a] = heap_words[b];
    heap_words[b] = held;
  endfunction

  // Apply one item to the predictor heap and return the result it yields.
  function automatic queue_outcome_t apply_to_heap(input bhpq_pkg::bhpq_op_e op,
                                                   input logic [VALUE_WIDTH-1:0] value);
    queue_outcome_t res;
    int unsigned pos;
    int unsigned parent;
    int unsigned left;
    int unsigned right;
    int unsigned pick;
    res = '0;
    res.status = bhpq_pkg::STATUS_OK;
    if (op == bhpq_pkg::OP_ENQUEUE) begin
      if (heap_len >= CAPACITY) begin
        // Full: drop the value, leave the heap alone.
        res.status = bhpq_pkg::STATUS_FULL;
      end else begin
        heap_words[heap_len] = value;
        heap_len++;
        // Sift up while strictly greater than the parent.
        pos = heap_len;
        while (pos > 1) begin
          parent = pos / 2;
          if (heap_words[pos-1] > heap_words[parent-1]) begin
            swap_heap_slots(parent - 1, pos - 1);
            pos = parent;
          end else begin
            break;
          end
        end
      end
    end else if (heap_len == 0) begin
      res.status = bhpq_pkg::STATUS_EMPTY;
    end else begin
      res.max_value = heap_words[0];
      heap_len--;
      heap_words[0] = heap_words[heap_len];
      // Sift down: take the larger child, the left one on a tie or when it is alone.
      pos = 1;
      while (2 * pos <= heap_len) begin
        left = 2 * pos;
        right = left + 1;
        pick = (right > heap_len || heap_words[left-1] >= heap_words[right-1]) ? left : right;
        if (heap_words[pos-1] < heap_words[pick-1]) begin
          swap_heap_slots(pos - 1, pick - 1);
          pos = pick;
        end else begin
          break;
        end
      end
    end
    res.entries_held = heap_len[COUNT_WIDTH-1:0];
    res.queue_empty = (heap_len == 0);
    return res;
  endfunction

  // Offer one beat on the slave side, idling at random first, and record its result.
  task automatic offer_item(input bhpq_pkg::bhpq_op_e op, input logic [VALUE_WIDTH-1:0] value,
                            input logic has_answer, input queue_outcome_t answer);
    queue_outcome_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      s_valid <= 1'b0;
      @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= value;
    s_user  <= op;
    do @(posedge clk_i); while (!s_ready);
    // Keep the predictor in step even where the answer is typed in.
    predicted = apply_to_heap(op, value);
    pending_outcomes.push_back(has_answer ? answer : predicted);
  endtask

  task automatic flag_mismatch(input string what, input longint unsigned want,
                               input longint unsigned got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("mismatch on %s: expected %0h, got %0h", what, want, got);
  endtask

  // Receiver: ready at the phase's idle rate, or held low through a long hold-off.
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      m_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (holds_served != hold_requests) begin
      holds_served <= holds_served + 1;
      m_ready <= 1'b0;
      hold_left <= 300;
    end else begin
      m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Checker: compare each accepted result beat with the oldest expectation.
  always @(posedge clk_i) begin
    queue_outcome_t want;
    if (rst_ni && m_valid && m_ready) begin
      if (pending_outcomes.size() == 0) begin
        flag_mismatch("unexpected result beat", 0, {m_user, m_data});
      end else begin
        want = pending_outcomes.pop_front();
        if (m_data[VALUE_WIDTH-1:0] !== want.max_value)
          flag_mismatch("max_value", want.max_value, m_data[VALUE_WIDTH-1:0]);
        if (m_user !== want.status)
          flag_mismatch("status", want.status, m_user);
        if (m_data[VALUE_WIDTH +: COUNT_WIDTH] !== want.entries_held)
          flag_mismatch("entries_held", want.entries_held, m_data[VALUE_WIDTH +: COUNT_WIDTH]);
        if (m_data[VALUE_WIDTH+COUNT_WIDTH] !== want.queue_empty)
          flag_mismatch("queue_empty", want.queue_empty, m_data[VALUE_WIDTH+COUNT_WIDTH]);
      end
    end
  end

  // Sender: reset, directed table, then three rounds of fill / mix / drain blocks.
  initial begin
    int               round;
    int               blk;
    int               n;
    int               count;
    int               deq_pct;
    bhpq_pkg::bhpq_op_e op;
    logic [VALUE_WIDTH-1:0] value;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk the directed table with a busy sender and a lazy receiver.
    send_idle_pct = 14;
    recv_idle_pct = 88;
    for (n = 0; n < NUM_DIRECTED; n++)
      offer_item(DIRECTED_ROWS[n].op, DIRECTED_ROWS[n].value,
                 DIRECTED_ROWS[n].has_answer, DIRECTED_ROWS[n].answer);

    for (round = 0; round < 3; round++) begin
      // Round 0: sender mostly busy, receiver mostly idle; round 1 the reverse;
      // round 2 neither idles.
      case (round)
        0: begin
          send_idle_pct = 14;
          recv_idle_pct = 88;
        end
        1: begin
          send_idle_pct = 88;
          recv_idle_pct = 14;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (blk = 0; blk < 3; blk++) begin
        // Fill past capacity, mix, then drain past empty.
        case (blk)
          0: begin
            count = 76;
            deq_pct = 2;
          end
          1: begin
            count = 16;
            deq_pct = 50;
          end
          default: begin
            count = 76;
            deq_pct = 98;
          end
        endcase
        // Stall the receiver for a long stretch so the output buffer backs up
        // and the slave side stops taking beats.
        if (round == 2 && blk == 1)
          hold_requests++;
        for (n = 0; n < count; n++) begin
          op = ($urandom_range(99) < deq_pct) ? bhpq_pkg::OP_DEQUEUE : bhpq_pkg::OP_ENQUEUE;
          case ($urandom_range(3))
            0: value = $urandom_range(7);
            1: begin
              case ($urandom_range(3))
                0: value = '0;
                1: value = TOP_VALUE;
                2: value = 32'h8000_0000;
                default: value = 32'h7fff_ffff;
              endcase
            end
            default: value = $urandom;
          endcase
          offer_item(op, value, 1'b0, '0);
        end
      end
      // Pause the sender until every result of the round is back.
      s_valid <= 1'b0;
      do @(posedge clk_i); while (pending_outcomes.size() != 0);
    end

    // Let a stray beat show up if there is one.
    repeat (10) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("binary_max_heap_priority_queue_top test passed");
    end else begin
      $display("binary_max_heap_priority_queue_top test failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #2_000_000;
    $display("binary_max_heap_priority_queue_top test failed");
    $finish;
  end

endmodule
